FILE: hw/rtl/ias_pkg.sv
// Shared beat types for the integer array sorter.
package ias_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               is_last_res;
    logic               overflowed;
  } out_beat_t;

endpackage

FILE: hw/rtl/integer_array_sorter.sv
// Integer array sorter: stable ascending sort of signed 32-bit values in one memory.
//
// Input: a beat (in_data) is taken on a rising edge with start high and busy low.
// Each value is placed into sorted order as it arrives. The stored elements
// that are larger than the new value move up one entry, one per cycle, through
// the single read port of the element memory. A beat is taken without the
// compare state when the store is empty or full; otherwise busy stays high
// until each larger value has moved up and the new value is written.
// Values that arrive with the store full are dropped and set the overflow flag.
// Output: after the beat marked is_last has been placed, the set comes out in
// ascending order, one beat per cycle on out_data with out_strobe high,
// each beat read from the memory in the emit state. The final beat has
// is_last_res set; overflowed is the same on every beat of the set. busy
// stays high until the emit is done, then the store is empty again.
// The receiver cannot stall: each out beat is valid for exactly one cycle.
// Reset (rst_n low, synchronous) empties the store and clears the overflow
// flag; memory contents are not cleared and need not be.
module integer_array_sorter
  import ias_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_strobe,
  output out_beat_t out_data
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_last_r, pend_last_nxt;

  logic [31:0]        mem [MAX_ELEMENTS];
  logic [31:0]        rdata_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [AW-1:0]      rd_addr;

  logic               accept;
  logic               has_room;
  logic               greater;

  assign accept   = start && (state_r == S_IDLE);
  assign has_room = count_r < CW'(MAX_ELEMENTS);
  assign greater  = $signed(rdata_r) > key_r;
  assign busy     = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = key_r;
    rd_addr       = pos_r - AW'(1);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_data.is_last;
          if (!has_room) begin
            ovf_nxt = 1'b1;
            if (in_data.is_last) begin
              state_nxt = S_EMIT;
              idx_nxt   = '0;
            end
          end else if (count_r == '0) begin
            // empty store: value lands in entry zero directly
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_data.value;
            count_nxt = CW'(1);
            if (in_data.is_last) begin
              state_nxt = S_EMIT;
              idx_nxt   = '0;
            end
          end else begin
            key_nxt   = in_data.value;
            pos_nxt   = count_r[AW-1:0];
            rd_addr   = count_r[AW-1:0] - AW'(1);
            state_nxt = S_CMP;
          end
        end
      end

      S_CMP: begin
        // rdata_r holds entry pos-1 here
        if (pos_r == '0 || !greater) begin
          wr_en     = 1'b1;
          wr_addr   = pos_r;
          wr_data   = key_r;
          count_nxt = count_r + CW'(1);
          if (last_r) begin
            state_nxt = S_EMIT;
            idx_nxt   = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = rdata_r;
          pos_nxt = pos_r - AW'(1);
          rd_addr = pos_r - AW'(2);
        end
      end

      S_EMIT: begin
        rd_addr  = idx_r;
        pend_nxt = 1'b1;
        if (idx_r == AW'(count_r - CW'(1))) begin
          pend_last_nxt = 1'b1;
          state_nxt     = S_FLUSH;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_FLUSH: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
  end

  // apart from reset, ovf_r is cleared only in the flush cycle, after the final beat has gone out
  assign out_strobe            = pend_r;
  assign out_data.sorted_value = $signed(rdata_r);
  assign out_data.is_last_res  = pend_last_r;
  assign out_data.overflowed   = ovf_r;

endmodule

FILE: sim/ias_checker.sv
// Checker for the integer array sorter: predicts each sorted set and compares out beats.
`timescale 1ns / 100ps

module ias_checker
  import ias_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_data,
  input  logic      out_strobe,
  input  out_beat_t out_data,
  output int        mismatch_count,
  output int        pending_count
);

  // Values of the set being loaded, kept in stable ascending order.
  logic signed [31:0] held_vals[$];
  logic               drop_seen;
  // Sorted beats that the block still owes.
  out_beat_t          sorted_due[$];

  // Equal values go after those already held, so arrival order is kept.
  function automatic int insert_pos(logic signed [31:0] v);
    int pos;
    pos = held_vals.size();
    for (int i = 0; i < held_vals.size(); i++) begin
      if (held_vals[i] > v) begin
        pos = i;
        break;
      end
    end
    return pos;
  endfunction

  task automatic load_value(in_beat_t beat);
    out_beat_t ob;
    if (held_vals.size() < MAX_ELEMENTS)
      held_vals.insert(insert_pos(beat.value), beat.value);
    else
      drop_seen = 1'b1;
    if (beat.is_last) begin
      for (int i = 0; i < held_vals.size(); i++) begin
        ob.sorted_value = held_vals[i];
        ob.is_last_res  = (i == held_vals.size() - 1);
        ob.overflowed   = drop_seen;
        sorted_due.push_back(ob);
      end
      held_vals.delete();
      drop_seen = 1'b0;
    end
  endtask

  task automatic check_beat(out_beat_t got);
    out_beat_t want;
    if (sorted_due.size() == 0) begin
      $error("out beat with nothing expected: sorted_value %0d", got.sorted_value);
      mismatch_count++;
      return;
    end
    want = sorted_due.pop_front();
    if (got.sorted_value !== want.sorted_value) begin
      $error("sorted_value: expected %0d, actual %0d", want.sorted_value, got.sorted_value);
      mismatch_count++;
    end
    if (got.is_last_res !== want.is_last_res) begin
      $error("is_last_res: expected %0b, actual %0b", want.is_last_res, got.is_last_res);
      mismatch_count++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0b, actual %0b", want.overflowed, got.overflowed);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_vals.delete();
      sorted_due.delete();
      drop_seen      = 1'b0;
      mismatch_count = 0;
    end else begin
      if (out_strobe === 1'b1) check_beat(out_data);
      if (start === 1'b1 && busy === 1'b0) load_value(in_data);
    end
    pending_count = sorted_due.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the integer array sorter: reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import ias_pkg::*;

  localparam int MAX_ELEMENTS = 64;
  localparam int RAND_ITEMS   = 210;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_strobe;
  out_beat_t out_data;
  int        mismatch_count;
  int        pending_count;
  int        items_sent;

  integer_array_sorter #(.MAX_ELEMENTS(MAX_ELEMENTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  ias_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_strobe    (out_strobe),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Holds start high until the beat is taken at an edge with busy low.
  task automatic send_value(logic signed [31:0] v, logic last, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 14) begin
      start   <= 1'b0;
      in_data <= in_beat_t'({$urandom, 1'($urandom)});
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{value: v, is_last: last};
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $signed($urandom_range(0, 15)) - 8;  // dense duplicates
    case ($urandom_range(0, 4))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -1;
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  task automatic send_set(int n);
    bit quiet;
    for (int i = 0; i < n; i++) begin
      quiet = (items_sent >= 80 && items_sent < 160);
      send_value(pick_value(), i == n - 1, !quiet);
    end
  endtask

  // Drop start so the beat just taken is not offered again, let the checker
  // queue the results of that beat, then wait until none of them are owed.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int set_idx;
    int n;
    int r;
    items_sent = 0;
    start   <= 1'b0;
    in_data <= '0;
    rst_n   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element sets at both extremes.
    send_value(32'sh8000_0000, 1'b1, 1'b0);
    send_value(32'sh7fff_ffff, 1'b1, 1'b0);
    // Extremes mixed with duplicates.
    send_value(7, 1'b0, 1'b1);
    send_value(-1, 1'b0, 1'b1);
    send_value(0, 1'b0, 1'b1);
    send_value(32'sh7fff_ffff, 1'b0, 1'b1);
    send_value(32'sh8000_0000, 1'b0, 1'b1);
    send_value(7, 1'b0, 1'b1);
    send_value(1, 1'b0, 1'b1);
    send_value(-1, 1'b1, 1'b1);
    // Descending then ascending input order.
    for (int i = 5; i >= 1; i--) send_value(i, i == 1, 1'b1);
    for (int i = -3; i <= 0; i++) send_value(i, i == 0, 1'b1);
    // Sender holds off until the block has emitted everything.
    wait_drained();

    set_idx = 0;
    while (items_sent < RAND_ITEMS) begin
      // Exactly full store, then overflow with the last beat dropped too.
      if (set_idx == 3) n = MAX_ELEMENTS;
      else if (set_idx == 7) n = MAX_ELEMENTS + 2;
      else begin
        r = $urandom_range(0, 9);
        if (r < 7) n = $urandom_range(1, 8);
        else if (r < 9) n = $urandom_range(9, 24);
        else n = $urandom_range(25, MAX_ELEMENTS);
      end
      send_set(n);
      if (set_idx == 10) wait_drained();
      set_idx++;
    end
    start <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ias_pkg.sv
hw/rtl/integer_array_sorter.sv
sim/ias_checker.sv
sim/tb_top.sv
